@@ sv/vpri_pkg.sv @@
// Shared types, constants and the popcount helper for the variant position rank index.
package vpri_pkg;

  localparam int unsigned NUM_BLOCKS_DEF   = 1024;
  localparam int unsigned MAX_VARIANTS_DEF = 65536;
  localparam int unsigned NUMBER_CAP       = 131072;  // numbering is 17 bits wide

  localparam int unsigned POS_W   = 16;
  localparam int unsigned OFF_W   = 6;
  localparam int unsigned RANK_W  = 7;
  localparam int unsigned NUM_W   = 17;
  localparam int unsigned BLK_MAX = 1 << (POS_W - OFF_W);

  localparam logic [63:0] M1 = 64'h5555555555555555;
  localparam logic [63:0] M2 = 64'h3333333333333333;
  localparam logic [63:0] M4 = 64'h0f0f0f0f0f0f0f0f;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RANK
  } state_e;

  typedef struct packed {
    logic              hit;
    logic [RANK_W-1:0] rank;
  } rank_t;

  function automatic logic [RANK_W-1:0] popcount64(input logic [63:0] x);
    logic [63:0] v;
    v = x - ((x >> 1) & M1);
    v = (v & M2) + ((v >> 2) & M2);
    v = (v + (v >> 4)) & M4;
    v = v + (v >> 8);
    v = v + (v >> 16);
    v = v + (v >> 32);
    return v[RANK_W-1:0];
  endfunction

endpackage

@@ sv/variant_position_rank_index.sv @@
// Variant position rank index: an add goes from accept through the execute state to the result;
// a query adds the rank state (bitmap and first-number read, then the rank offset memory read).
// One item at a time: the next beat is taken once the result is registered.
// After reset a clearing pass writes each of the min(NUM_BLOCKS, 1024) bitmap words once
// (1024 by default), with in_stall_o held high.
module variant_position_rank_index #(
  parameter int unsigned NUM_BLOCKS   = vpri_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned MAX_VARIANTS = vpri_pkg::MAX_VARIANTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [15:0] position_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        present_o,
  output logic [15:0] first_index_o,
  output logic        error_o
);

  localparam int unsigned BLK_DEPTH = NUM_BLOCKS < vpri_pkg::BLK_MAX ?
                                      NUM_BLOCKS : vpri_pkg::BLK_MAX;
  localparam int unsigned BIW       = BLK_DEPTH > 1 ? $clog2(BLK_DEPTH) : 1;
  localparam int unsigned TAB_DEPTH = BLK_DEPTH * 64;
  localparam int unsigned LIMIT     = MAX_VARIANTS < vpri_pkg::NUMBER_CAP ?
                                      MAX_VARIANTS : vpri_pkg::NUMBER_CAP;

  vpri_pkg::state_e state_q, state_d;
  logic [BIW-1:0]   clr_q, clr_d;

  // item under work
  vpri_pkg::cmd_e   cmd_q;
  logic [15:0]      pos_q;

  // add bookkeeping
  logic [15:0]      last_q, last_d;
  logic             any_q, any_d;
  logic [16:0]      next_q, next_d;
  logic [15:0]      cnt_q, cnt_d;
  logic [6:0]       npos_q, npos_d;
  logic [63:0]      cur_bits_q, cur_bits_d;

  // memories
  logic [63:0]      bm_mem [BLK_DEPTH];
  logic [15:0]      first_mem [BLK_DEPTH];
  logic [15:0]      tab_mem [TAB_DEPTH];

  logic             bm_we, first_we, tab_we, blk_re, tab_re;
  logic [BIW-1:0]   bm_waddr, blk_raddr;
  logic [63:0]      bm_wdata;
  logic [BIW+5:0]   tab_waddr, tab_raddr;
  logic [15:0]      tab_wdata;
  logic [63:0]      bits_rd_q;
  logic [15:0]      first_rd_q, tab_rd_q;

  // output register
  logic             out_valid_q, out_valid_d;
  logic             out_ld;
  logic             present_q, present_d;
  logic [15:0]      index_q, index_d;
  logic             error_q, error_d;

  logic             out_free, in_range, add_err, new_blk, new_pos;
  logic [BIW-1:0]   blk_idx;
  logic [15:0]      cnt_base;
  logic [6:0]       npos_base;
  logic [63:0]      bits_base;
  vpri_pkg::rank_t  rank_s;

  vpri_rank u_rank (
    .bits_i   (bits_rd_q),
    .offset_i (pos_q[5:0]),
    .rank_o   (rank_s)
  );

  assign in_stall_o = (state_q != vpri_pkg::ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign blk_idx    = pos_q[6 +: BIW];
  assign in_range   = 32'(pos_q[15:6]) < 32'(NUM_BLOCKS);
  assign add_err    = !in_range || (any_q && (pos_q < last_q)) || (32'(next_q) >= 32'(LIMIT));
  assign new_blk    = !any_q || (pos_q[15:6] > last_q[15:6]);
  assign new_pos    = !any_q || (pos_q > last_q);
  assign cnt_base   = new_blk ? 16'd0 : cnt_q;
  assign npos_base  = new_blk ? 7'd0 : npos_q;
  assign bits_base  = new_blk ? 64'd0 : cur_bits_q;
  assign blk_raddr  = position_i[6 +: BIW];
  assign tab_raddr  = {blk_idx, rank_s.rank[5:0]};

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    last_d      = last_q;
    any_d       = any_q;
    next_d      = next_q;
    cnt_d       = cnt_q;
    npos_d      = npos_q;
    cur_bits_d  = cur_bits_q;
    bm_we       = 1'b0;
    bm_waddr    = blk_idx;
    bm_wdata    = bits_base | (64'd1 << pos_q[5:0]);
    first_we    = 1'b0;
    tab_we      = 1'b0;
    tab_waddr   = {blk_idx, npos_base[5:0]};
    tab_wdata   = cnt_base;
    blk_re      = 1'b0;
    tab_re      = 1'b0;
    out_ld      = 1'b0;
    present_d   = present_q;
    index_d     = index_q;
    error_d     = error_q;
    unique case (state_q)
      vpri_pkg::ST_CLEAR: begin
        bm_we    = 1'b1;
        bm_waddr = clr_q;
        bm_wdata = '0;
        if (clr_q == BIW'(BLK_DEPTH - 1)) begin
          state_d = vpri_pkg::ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      vpri_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          blk_re  = 1'b1;
          state_d = vpri_pkg::ST_EXEC;
        end
      end
      vpri_pkg::ST_EXEC: begin
        if (cmd_q == vpri_pkg::CMD_QUERY) begin
          tab_re  = 1'b1;
          state_d = vpri_pkg::ST_RANK;
        end else if (out_free) begin
          out_ld    = 1'b1;
          present_d = 1'b0;
          index_d   = '0;
          error_d   = add_err;
          state_d   = vpri_pkg::ST_IDLE;
          if (!add_err) begin
            first_we = new_blk;
            cnt_d    = cnt_base + 16'd1;
            npos_d   = npos_base;
            cur_bits_d = bits_base;
            if (new_pos) begin
              bm_we      = 1'b1;
              tab_we     = 1'b1;
              cur_bits_d = bm_wdata;
              npos_d     = npos_base + 7'd1;
            end
            next_d = next_q + 17'd1;
            last_d = pos_q;
            any_d  = 1'b1;
          end
        end
      end
      vpri_pkg::ST_RANK: begin
        if (out_free) begin
          out_ld    = 1'b1;
          present_d = in_range && rank_s.hit;
          index_d   = (in_range && rank_s.hit) ? first_rd_q + tab_rd_q : 16'd0;
          error_d   = 1'b0;
          state_d   = vpri_pkg::ST_IDLE;
        end
      end
      default: state_d = vpri_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_ld) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vpri_pkg::ST_CLEAR;
      clr_q       <= '0;
      last_q      <= '0;
      any_q       <= 1'b0;
      next_q      <= '0;
      cnt_q       <= '0;
      npos_q      <= '0;
      cur_bits_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      last_q      <= last_d;
      any_q       <= any_d;
      next_q      <= next_d;
      cnt_q       <= cnt_d;
      npos_q      <= npos_d;
      cur_bits_q  <= cur_bits_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (blk_re) begin
      cmd_q <= vpri_pkg::cmd_e'(cmd_i);
      pos_q <= position_i;
    end
    if (out_ld) begin
      present_q <= present_d;
      index_q   <= index_d;
      error_q   <= error_d;
    end
  end

  // bitmap memory
  always_ff @(posedge clk_i) begin
    if (bm_we) begin
      bm_mem[bm_waddr] <= bm_wdata;
    end
    if (blk_re) begin
      bits_rd_q <= bm_mem[blk_raddr];
    end
  end

  // first variant number per block
  always_ff @(posedge clk_i) begin
    if (first_we) begin
      first_mem[blk_idx] <= next_q[15:0];
    end
    if (blk_re) begin
      first_rd_q <= first_mem[blk_raddr];
    end
  end

  // offset of each distinct position within its block
  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
    if (tab_re) begin
      tab_rd_q <= tab_mem[tab_raddr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign present_o     = present_q;
  assign first_index_o = index_q;
  assign error_o       = error_q;

endmodule

@@ sv/vpri_rank.sv @@
// Presence test and rank (set bits below the offset) of one bitmap word.
module vpri_rank (
  input  logic [63:0]              bits_i,
  input  logic [vpri_pkg::OFF_W-1:0] offset_i,
  output vpri_pkg::rank_t          rank_o
);

  logic [63:0] below_mask;

  // offset zero gives an empty mask, so rank zero
  assign below_mask  = (64'd1 << offset_i) - 64'd1;
  assign rank_o.hit  = bits_i[offset_i];
  assign rank_o.rank = vpri_pkg::popcount64(bits_i & below_mask);

endmodule

@@ sv/vpri_chk.sv @@
// Port-level checker for the variant position rank index, bound to the top level.
module vpri_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        cmd_i,
  input logic [15:0] position_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        present_o,
  input logic [15:0] first_index_o,
  input logic        error_o
);

  // a result beat that is held back stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // one item at a time: after an accepted beat the input side is busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second beat accepted while an item is in work");

  // a miss or an add never reports an index
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !present_o |-> first_index_o == 16'd0)
    else $error("nonzero index without a hit");

  // a hit comes only from a query, which never flags an error
  a_hit_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && present_o |-> !error_o)
    else $error("hit and error reported together");

endmodule

bind variant_position_rank_index vpri_chk u_vpri_chk (.*);

@@ sim/rank_index_checker.sv @@
// Checker for the variant position rank index: mirrors the index and compares every answer.
module rank_index_checker #(
  parameter int unsigned NUM_BLOCKS   = vpri_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned MAX_VARIANTS = vpri_pkg::MAX_VARIANTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        cmd_i,
  input  logic [15:0] position_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        present_i,
  input  logic [15:0] first_index_i,
  input  logic        error_i,
  output int          mismatches_o,
  output int          outstanding_o
);

  localparam int unsigned NUMBER_LIMIT =
    (MAX_VARIANTS < vpri_pkg::NUMBER_CAP) ? MAX_VARIANTS : vpri_pkg::NUMBER_CAP;

  typedef struct packed {
    logic        present;
    logic [15:0] first_index;
    logic        error;
  } answer_t;

  // mirrored index
  bit [63:0] block_bits   [NUM_BLOCKS];
  bit [15:0] block_base   [NUM_BLOCKS];
  bit [15:0] rank_offsets [NUM_BLOCKS*64];
  bit [15:0] last_pos;
  bit        any_added;
  bit [16:0] next_number;
  bit [15:0] run_count;
  bit [6:0]  run_positions;

  answer_t answers_due [$];
  answer_t want;
  answer_t got;
  int      mismatch_count;

  function automatic answer_t index_answer(vpri_pkg::cmd_e cmd, logic [15:0] pos);
    answer_t     a;
    int unsigned blk;
    int unsigned off;
    logic [63:0] below;
    int unsigned rank;
    a   = '0;
    blk = 32'(pos[15:6]);
    off = 32'(pos[5:0]);
    if (cmd == vpri_pkg::CMD_QUERY) begin
      if (blk < NUM_BLOCKS && block_bits[blk][off]) begin
        below         = block_bits[blk] & ((64'd1 << off) - 64'd1);
        rank          = $countones(below);
        a.present     = 1'b1;
        a.first_index = block_base[blk] + rank_offsets[blk*64 + rank];
      end
      return a;
    end
    if (blk >= NUM_BLOCKS || (any_added && pos < last_pos) ||
        32'(next_number) >= NUMBER_LIMIT) begin
      a.error = 1'b1;
      return a;
    end
    // entering a new block restarts the per-block counters
    if (!any_added || blk > 32'(last_pos[15:6])) begin
      block_base[blk] = next_number[15:0];
      run_count       = '0;
      run_positions   = '0;
    end
    // only the first variant at a position gets a bit and an offset entry
    if (!any_added || pos > last_pos) begin
      block_bits[blk][off]                       = 1'b1;
      rank_offsets[blk*64 + run_positions[5:0]]  = run_count;
      run_positions                              = run_positions + 7'd1;
    end
    run_count   = run_count + 16'd1;
    next_number = next_number + 17'd1;
    last_pos    = pos;
    any_added   = 1'b1;
    return a;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BLOCKS; b++) block_bits[b] = '0;
      last_pos       = '0;
      any_added      = 1'b0;
      next_number    = '0;
      run_count      = '0;
      run_positions  = '0;
      mismatch_count = 0;
      answers_due.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{present: present_i, first_index: first_index_i, error: error_i};
        if (answers_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected beat present=%0b first_index=%0d error=%0b",
                     $realtime, got.present, got.first_index, got.error);
        end else begin
          want = answers_due.pop_front();
          if (got.present !== want.present || got.first_index !== want.first_index ||
              got.error !== want.error) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: mismatch expected present=%0b first_index=%0d error=%0b, %s",
                       $realtime, want.present, want.first_index, want.error,
                       $sformatf("got present=%0b first_index=%0d error=%0b",
                                 got.present, got.first_index, got.error));
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        answers_due = {answers_due, index_answer(vpri_pkg::cmd_e'(cmd_i), position_i)};
    end
    mismatches_o  <= mismatch_count;
    outstanding_o <= answers_due.size();
  end

endmodule

@@ sim/testbench.sv @@
// Top of the rank index testbench: clock, reset, stimulus, stalls and the verdict.
module testbench;

  localparam int unsigned NUM_BLOCKS   = vpri_pkg::NUM_BLOCKS_DEF;
  localparam int unsigned MAX_VARIANTS = vpri_pkg::MAX_VARIANTS_DEF;
  localparam int unsigned RANDOM_ITEMS = 1100;
  // the limit lies well above the slowest run (clearing pass, every item behind
  // the longest gaps and stall bursts, the long hold-off)
  localparam int unsigned CYCLE_LIMIT  = 1500000;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  vpri_pkg::cmd_e cmd;
  logic [15:0]    position;
  logic           out_valid;
  logic           out_stall;
  logic           present;
  logic [15:0]    first_index;
  logic           add_error;

  int          mismatches;
  int          outstanding;
  int          results_seen = 0;
  int          cycle_count;

  // what the sender knows about the adds it has made
  bit          tb_any;
  logic [15:0] cursor;
  int unsigned numbered;
  logic [15:0] added_pos [$];
  bit          tx_quiet;
  bit          rx_quiet;

  variant_position_rank_index #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .MAX_VARIANTS(MAX_VARIANTS)
  ) u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .cmd_i        (cmd),
    .position_i   (position),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .present_o    (present),
    .first_index_o(first_index),
    .error_o      (add_error)
  );

  rank_index_checker #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .MAX_VARIANTS(MAX_VARIANTS)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .cmd_i        (cmd),
    .position_i   (position),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .present_i    (present),
    .first_index_i(first_index),
    .error_i      (add_error),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: errors");
    $finish;
  end

  always @(posedge clk)
    if (out_valid && !out_stall) results_seen <= results_seen + 1;

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Drives one beat at a falling edge and holds it until the block takes it.
  task automatic offer(vpri_pkg::cmd_e c, logic [15:0] p);
    int gap;
    if (c == vpri_pkg::CMD_ADD && (!tb_any || p >= cursor) && numbered < MAX_VARIANTS) begin
      if (!tb_any || p > cursor) added_pos = {added_pos, p};
      tb_any = 1'b1;
      cursor = p;
      numbered++;
    end
    in_valid = 1'b1;
    cmd      = c;
    position = p;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    gap = tx_quiet ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic random_item();
    int          r;
    int          s;
    int unsigned step;
    logic [15:0] p;
    r = $urandom_range(0, 99);
    if (r < 48) begin
      // mostly small forward steps, repeats, and a few jumps across blocks
      s = $urandom_range(0, 99);
      if (s < 30) step = 0;
      else if (s < 80) step = $urandom_range(1, 8);
      else if (s < 95) step = $urandom_range(9, 200);
      else step = $urandom_range(201, 1000);
      p = (cursor + step > 65535) ? 16'hFFFF : 16'(cursor + step);
      offer(vpri_pkg::CMD_ADD, p);
    end else if (r < 53) begin
      if (tb_any && cursor > 0)
        offer(vpri_pkg::CMD_ADD, 16'($urandom_range(0, cursor - 1)));
      else offer(vpri_pkg::CMD_ADD, cursor);
    end else if (r < 80) begin
      if (added_pos.size() > 0)
        offer(vpri_pkg::CMD_QUERY, added_pos[$urandom_range(0, added_pos.size() - 1)]);
      else offer(vpri_pkg::CMD_QUERY, 16'($urandom));
    end else if (r < 90) begin
      offer(vpri_pkg::CMD_QUERY, {cursor[15:6], 6'($urandom)});
    end else begin
      offer(vpri_pkg::CMD_QUERY, 16'($urandom));
    end
  endtask

  // output side: random stall bursts, one long hold-off, quiet for the closing adds
  initial begin
    int burst;
    int r;
    int holdoff;
    bit held;
    burst     = 0;
    holdoff   = 0;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 300) begin
        held    = 1'b1;
        holdoff = 250;
      end
      if (holdoff > 0) begin
        out_stall = 1'b1;
        holdoff--;
      end else if (rx_quiet) begin
        out_stall = 1'b0;
      end else if (burst > 0) begin
        burst--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_stall = 1'b0;
          burst     = $urandom_range(0, 6);
        end else if (r < 95) begin
          out_stall = 1'b1;
          burst     = $urandom_range(0, 2);
        end else begin
          out_stall = 1'b1;
          burst     = $urandom_range(10, 40);
        end
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    cmd          = vpri_pkg::CMD_ADD;
    position     = '0;
    tx_quiet     = 1'b0;
    rx_quiet     = 1'b0;
    tb_any       = 1'b0;
    cursor       = '0;
    numbered     = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty index, position zero, repeats, offset zero, backwards adds
    offer(vpri_pkg::CMD_QUERY, 16'd0);
    offer(vpri_pkg::CMD_QUERY, 16'hFFFF);
    offer(vpri_pkg::CMD_ADD, 16'd0);
    offer(vpri_pkg::CMD_ADD, 16'd0);
    offer(vpri_pkg::CMD_QUERY, 16'd0);
    offer(vpri_pkg::CMD_ADD, 16'd1);
    offer(vpri_pkg::CMD_ADD, 16'd1);
    offer(vpri_pkg::CMD_ADD, 16'd1);
    offer(vpri_pkg::CMD_ADD, 16'd62);
    offer(vpri_pkg::CMD_ADD, 16'd63);
    offer(vpri_pkg::CMD_QUERY, 16'd63);
    offer(vpri_pkg::CMD_QUERY, 16'd1);
    offer(vpri_pkg::CMD_QUERY, 16'd62);
    offer(vpri_pkg::CMD_QUERY, 16'd2);
    offer(vpri_pkg::CMD_ADD, 16'd61);
    offer(vpri_pkg::CMD_ADD, 16'd64);
    offer(vpri_pkg::CMD_QUERY, 16'd64);
    offer(vpri_pkg::CMD_ADD, 16'd127);
    offer(vpri_pkg::CMD_ADD, 16'd128);
    offer(vpri_pkg::CMD_QUERY, 16'd127);
    offer(vpri_pkg::CMD_QUERY, 16'd128);
    offer(vpri_pkg::CMD_QUERY, 16'hFFFF);
    offer(vpri_pkg::CMD_ADD, 16'd0);
    offer(vpri_pkg::CMD_QUERY, 16'd0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      tx_quiet = (i % 200) >= 170;
      random_item();
    end

    // top position, then a backwards add and a query of the last block
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    offer(vpri_pkg::CMD_ADD, 16'hFFFF);
    offer(vpri_pkg::CMD_ADD, 16'hFFFF);
    offer(vpri_pkg::CMD_ADD, 16'd5);
    offer(vpri_pkg::CMD_QUERY, 16'hFFFF);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    for (int i = 0; i < 20; i++)
      offer(vpri_pkg::CMD_QUERY, added_pos[$urandom_range(0, added_pos.size() - 1)]);
    in_valid = 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (outstanding != 0) $display("%0d answers never arrived", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
